// File: rtl/core/stit_pkg.sv
// Package for the sorted timestamp insert table.
// Holds field widths, table depth, action and status codes, and the compare result type.
// No dependencies.
`default_nettype none

package stit_pkg;

  // Table depth and derived index widths
  localparam int DEPTH   = 1024;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  // Fixed field widths of the stream items
  localparam int ACT_W   = 2;
  localparam int TS_W    = 48;
  localparam int WORD_W  = 32;
  localparam int RIDX_W  = 10;
  localparam int STAT_W  = 3;
  localparam int POS_W   = 10;
  localparam int OCNT_W  = 11;
  localparam int ENTRY_W = TS_W + 2 * WORD_W;

  // Packed stream widths, padded to whole bytes
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 136;
  localparam int IN_PAD_W   = IN_DATA_W - (TS_W + 2 * WORD_W + RIDX_W);

  // Action codes
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_READ_OK   = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd4;
  localparam logic [STAT_W-1:0] ST_CLEARED   = 3'd5;

  // Result of the shared key compare unit
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

`default_nettype wire

// File: rtl/core/stit_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Self-contained, no package dependency.
`default_nettype none

module stit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/stit_cmp.sv
// Shared key compare unit used by every binary search step.
// Depends on stit_pkg for the key width and the result struct.
`default_nettype none

module stit_cmp (
  input  wire logic [stit_pkg::TS_W-1:0] new_key,
  input  wire logic [stit_pkg::TS_W-1:0] stored_key,
  output stit_pkg::cmp_res_t             res
);

  import stit_pkg::*;

  // Stored key below the new key moves the search up; equal marks a duplicate
  always_comb begin
    res.lt = (stored_key < new_key);
    res.eq = (stored_key == new_key);
  end

endmodule

`default_nettype wire

// File: rtl/core/sorted_timestamp_insert_table_core.sv
// Top level of the sorted timestamp insert table: sequencer, fill count and output register.
// Depends on stit_pkg, stit_ram and stit_cmp.
//
//  channel | ports          | payload
//  --------+----------------+-----------------------------------------------------
//  input   | in_t*          | tuser: action; tdata: timestamp, x, y, read index
//  result  | out_t*         | tuser: status; tdata: position, count, ts, x, y
//
// An insert runs s search steps (at most ceil(log2(count+1))) and, unless it is refused or
// appends, shifts the entries after its position up by one before the write: the search and
// the shift both go through the single read port of the entry memory, and each search step
// uses the shared compare. A read passes through S_RDW to S_OUT; a clear or an unused action
// goes straight to S_OUT. in_tready is high only when idle.
// Reset is synchronous and clears only the control state and the fill count.
// A stalled result holds in the output register; the next transaction is still taken and
// worked on, and its result waits in S_OUT until the register is free.
`default_nettype none

module sorted_timestamp_insert_table_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // tdata: timestamp_ms[47:0], x_value[79:48], y_value[111:80], read_index[121:112], zero pad
  input  wire logic [stit_pkg::IN_DATA_W-1:0]     in_tdata,
  // tuser: action[1:0]
  input  wire logic [stit_pkg::ACT_W-1:0]         in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // tdata: position[9:0], entry_count[20:10], read_timestamp[68:21], read_x[100:69],
  //        read_y[132:101], zero pad
  output logic      [stit_pkg::OUT_DATA_W-1:0]    out_tdata,
  // tuser: status[2:0]
  output logic      [stit_pkg::STAT_W-1:0]        out_tuser
);

  import stit_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SRCH  = 7'b0000010,
    S_CMP   = 7'b0000100,
    S_SHIFT = 7'b0001000,
    S_WRITE = 7'b0010000,
    S_RDW   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Control state
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [CNT_W-1:0]  lo_r, lo_nxt;
  logic [CNT_W-1:0]  hi_r, hi_nxt;
  logic [IDX_W-1:0]  mid_r, mid_nxt;
  logic              found_r, found_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic [IDX_W-1:0]  src_r, src_nxt;
  logic              pend_r, pend_nxt;
  logic [IDX_W-1:0]  dst_r, dst_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Captured item
  logic [TS_W-1:0]   key_r, key_nxt;
  logic [WORD_W-1:0] xw_r, xw_nxt;
  logic [WORD_W-1:0] yw_r, yw_nxt;

  // Pending result
  logic [STAT_W-1:0] res_stat_r, res_stat_nxt;
  logic [POS_W-1:0]  res_pos_r, res_pos_nxt;
  logic [TS_W-1:0]   res_ts_r, res_ts_nxt;
  logic [WORD_W-1:0] res_x_r, res_x_nxt;
  logic [WORD_W-1:0] res_y_r, res_y_nxt;

  // Output register
  logic [STAT_W-1:0]     out_stat_r, out_stat_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // Memory ports
  logic               ram_wr_en;
  logic [IDX_W-1:0]   ram_wr_addr;
  logic [ENTRY_W-1:0] ram_wr_data;
  logic               ram_rd_en;
  logic [IDX_W-1:0]   ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_data;

  cmp_res_t          cmp_res;
  logic              in_fire;
  logic [CNT_W-1:0]  mid_calc;
  logic [RIDX_W-1:0] in_ridx;
  logic [ACT_W-1:0]  in_act;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid & in_tready;
  assign in_ridx    = in_tdata[TS_W+2*WORD_W +: RIDX_W];
  assign in_act     = in_tuser;
  assign mid_calc   = lo_r + ((hi_r - lo_r) >> 1);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

  stit_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH),
    .AW    (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  stit_cmp u_cmp (
    .new_key    (key_r),
    .stored_key (ram_rd_data[ENTRY_W-1 -: TS_W]),
    .res        (cmp_res)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    found_nxt     = found_r;
    left_nxt      = left_r;
    src_nxt       = src_r;
    pend_nxt      = pend_r;
    dst_nxt       = dst_r;
    key_nxt       = key_r;
    xw_nxt        = xw_r;
    yw_nxt        = yw_r;
    res_stat_nxt  = res_stat_r;
    res_pos_nxt   = res_pos_r;
    res_ts_nxt    = res_ts_r;
    res_x_nxt     = res_x_r;
    res_y_nxt     = res_y_r;
    out_stat_nxt  = out_stat_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = dst_r;
    ram_wr_data   = ram_rd_data;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = src_r;

    // Drop the output register once its transaction completes
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          key_nxt     = in_tdata[TS_W-1:0];
          xw_nxt      = in_tdata[TS_W +: WORD_W];
          yw_nxt      = in_tdata[TS_W+WORD_W +: WORD_W];
          res_stat_nxt = ST_BAD_INDEX;
          res_pos_nxt  = '0;
          res_ts_nxt   = '0;
          res_x_nxt    = '0;
          res_y_nxt    = '0;
          lo_nxt       = '0;
          hi_nxt       = fill_r;
          found_nxt    = 1'b0;
          state_nxt    = S_OUT;
          case (in_act)
            ACT_INSERT: begin
              state_nxt = S_SRCH;
            end
            ACT_READ: begin
              if (32'(in_ridx) < 32'(fill_r)) begin
                ram_rd_en    = 1'b1;
                ram_rd_addr  = IDX_W'(in_ridx);
                res_stat_nxt = ST_READ_OK;
                res_pos_nxt  = in_ridx;
                state_nxt    = S_RDW;
              end
            end
            ACT_CLEAR: begin
              fill_nxt     = '0;
              res_stat_nxt = ST_CLEARED;
            end
            default: begin
              res_stat_nxt = ST_BAD_INDEX;
            end
          endcase
        end
      end

      // Issue one search probe, or decide once the range is empty
      S_SRCH: begin
        if (lo_r < hi_r) begin
          mid_nxt     = IDX_W'(mid_calc);
          ram_rd_en   = 1'b1;
          ram_rd_addr = IDX_W'(mid_calc);
          state_nxt   = S_CMP;
        end else if (found_r) begin
          res_stat_nxt = ST_DUPLICATE;
          state_nxt    = S_OUT;
        end else if (32'(fill_r) >= DEPTH) begin
          res_stat_nxt = ST_FULL;
          state_nxt    = S_OUT;
        end else if (lo_r == fill_r) begin
          state_nxt = S_WRITE;
        end else begin
          left_nxt  = fill_r - lo_r;
          src_nxt   = IDX_W'(fill_r - CNT_W'(1));
          pend_nxt  = 1'b0;
          state_nxt = S_SHIFT;
        end
      end

      // Narrow the range with the probed key
      S_CMP: begin
        if (cmp_res.lt) begin
          lo_nxt = CNT_W'(mid_r) + CNT_W'(1);
        end else begin
          hi_nxt = CNT_W'(mid_r);
        end
        if (cmp_res.eq) begin
          found_nxt = 1'b1;
        end
        state_nxt = S_SRCH;
      end

      // Move later entries up by one: read one entry while writing the one before
      S_SHIFT: begin
        if (pend_r) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = dst_r;
          ram_wr_data = ram_rd_data;
        end
        if (left_r != '0) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = src_r;
          dst_nxt     = src_r + IDX_W'(1);
          src_nxt     = src_r - IDX_W'(1);
          left_nxt    = left_r - CNT_W'(1);
          pend_nxt    = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_WRITE;
        end
      end

      // Store the new point at its place
      S_WRITE: begin
        ram_wr_en    = 1'b1;
        ram_wr_addr  = IDX_W'(lo_r);
        ram_wr_data  = {key_r, xw_r, yw_r};
        fill_nxt     = fill_r + CNT_W'(1);
        res_stat_nxt = ST_INSERTED;
        res_pos_nxt  = POS_W'(lo_r);
        state_nxt    = S_OUT;
      end

      // Capture the entry read
      S_RDW: begin
        res_ts_nxt = ram_rd_data[ENTRY_W-1 -: TS_W];
        res_x_nxt  = ram_rd_data[2*WORD_W-1 -: WORD_W];
        res_y_nxt  = ram_rd_data[WORD_W-1:0];
        state_nxt  = S_OUT;
      end

      // Hand the result to the output register when it is free
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = res_stat_r;
          out_data_nxt  = {3'd0, res_y_r, res_x_r, res_ts_r, OCNT_W'(fill_r), res_pos_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      left_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      left_r      <= left_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    key_r      <= key_nxt;
    xw_r       <= xw_nxt;
    yw_r       <= yw_nxt;
    res_stat_r <= res_stat_nxt;
    res_pos_r  <= res_pos_nxt;
    res_ts_r   <= res_ts_nxt;
    res_x_r    <= res_x_nxt;
    res_y_r    <= res_y_nxt;
    out_stat_r <= out_stat_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// File: test/stit_track_checker.sv
`timescale 1ns / 100ps
// Checker for the sorted timestamp insert table: watches both stream channels,
// predicts each result from its own copy of the table and compares field by field.
// Depends on stit_pkg.

module stit_track_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [stit_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [stit_pkg::ACT_W-1:0]      in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [stit_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic [stit_pkg::STAT_W-1:0]     out_tuser,
  output int                              fail_count,
  output int                              outstanding
);

  import stit_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [OCNT_W-1:0] entry_count;
    logic [TS_W-1:0]   read_ts;
    logic [WORD_W-1:0] read_x;
    logic [WORD_W-1:0] read_y;
  } table_reply_t;

  // Shadow table, kept sorted by timestamp
  logic [TS_W-1:0]   key_mem   [DEPTH];
  logic [WORD_W-1:0] east_mem  [DEPTH];
  logic [WORD_W-1:0] north_mem [DEPTH];
  int                held;
  int                mismatches = 0;
  table_reply_t      pending_replies [$];

  assign fail_count = mismatches;

  // Apply one action to the shadow table and return the reply it should give
  function automatic table_reply_t apply_table_action(input logic [ACT_W-1:0]  act,
                                                      input logic [TS_W-1:0]   ts,
                                                      input logic [WORD_W-1:0] xw,
                                                      input logic [WORD_W-1:0] yw,
                                                      input logic [RIDX_W-1:0] ridx);
    table_reply_t r;
    int           lo;
    int           hi;
    int           mid;
    int           i;
    r        = '0;
    r.status = ST_BAD_INDEX;
    case (act)
      ACT_INSERT: begin
        // find the first slot whose key is not below the new one
        lo = 0;
        hi = held;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (key_mem[mid] < ts) lo = mid + 1;
          else hi = mid;
        end
        if (lo < held && key_mem[lo] == ts) begin
          r.status = ST_DUPLICATE;
        end else if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // shift later entries up by one and drop the point in
          for (i = held; i > lo; i--) begin
            key_mem[i]   = key_mem[i-1];
            east_mem[i]  = east_mem[i-1];
            north_mem[i] = north_mem[i-1];
          end
          key_mem[lo]   = ts;
          east_mem[lo]  = xw;
          north_mem[lo] = yw;
          held++;
          r.status   = ST_INSERTED;
          r.position = lo[POS_W-1:0];
        end
      end
      ACT_READ: begin
        if (int'(ridx) < held) begin
          r.status   = ST_READ_OK;
          r.position = ridx;
          r.read_ts  = key_mem[ridx];
          r.read_x   = east_mem[ridx];
          r.read_y   = north_mem[ridx];
        end
      end
      ACT_CLEAR: begin
        held     = 0;
        r.status = ST_CLEARED;
      end
      default: ;
    endcase
    r.entry_count = held[OCNT_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      if (mismatches < 10)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Compare leaving results first, then queue the reply for an accepted item
  always @(posedge clk) begin
    table_reply_t want;
    if (!rst_n) begin
      held = 0;
      pending_replies.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_replies.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result transaction with nothing pending, status %0d",
                     $time, out_tuser);
          mismatches++;
        end else begin
          want = pending_replies.pop_front();
          check_field("status",         want.status,      out_tuser);
          check_field("position",       want.position,    out_tdata[9:0]);
          check_field("entry_count",    want.entry_count, out_tdata[20:10]);
          check_field("read_timestamp", want.read_ts,     out_tdata[68:21]);
          check_field("read_x",         want.read_x,      out_tdata[100:69]);
          check_field("read_y",         want.read_y,      out_tdata[132:101]);
        end
      end
      if (in_tvalid && in_tready)
        pending_replies.insert(pending_replies.size(),
                               apply_table_action(in_tuser, in_tdata[47:0],
                                                  in_tdata[79:48], in_tdata[111:80],
                                                  in_tdata[121:112]));
    end
    outstanding <= pending_replies.size();
  end

endmodule

// File: test/tb_sorted_timestamp_insert_table_core.sv
`timescale 1ns / 100ps
// Testbench top for the sorted timestamp insert table: clock, reset, input stimulus,
// result back-pressure and the verdict. Depends on stit_pkg, the core and stit_track_checker.

module tb_sorted_timestamp_insert_table_core;
  import stit_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 1200;
  localparam int FILL_ENTRIES    = 300;
  localparam int RANDOM_ITEMS    = 210;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [ACT_W-1:0]      in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]     out_tuser;
  int                    fail_count;
  int                    outstanding;

  // Stimulus-side knobs
  int                    tx_idle_pct;
  int                    rx_idle_pct;
  int                    hold_requests;
  logic [TS_W-1:0]       live_keys [$];

  sorted_timestamp_insert_table_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  stit_track_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Give up well beyond the slowest legal run
  initial begin
    #60_000_000;
    $display("FAIL sorted_timestamp_insert_table_core");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested
  initial begin
    int seen_requests;
    int hold_left;
    seen_requests = 0;
    hold_left     = 0;
    out_tready    = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != seen_requests) begin
        seen_requests = hold_requests;
        hold_left     = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  function automatic bit key_is_live(input logic [TS_W-1:0] k);
    foreach (live_keys[i])
      if (live_keys[i] == k) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [TS_W-1:0] rand_key();
    logic [31:0] hi_w;
    logic [31:0] lo_w;
    hi_w = $urandom();
    lo_w = $urandom();
    case ($urandom_range(0, 2))
      0:       return {hi_w[15:0], lo_w};
      1:       return TS_W'($urandom_range(0, 255));
      default: return {TS_W{1'b1}} - TS_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one transaction and hold it until accepted, then track the live keys
  task automatic offer(input logic [ACT_W-1:0]  act,
                       input logic [TS_W-1:0]   ts,
                       input logic [WORD_W-1:0] xw,
                       input logic [WORD_W-1:0] yw,
                       input logic [RIDX_W-1:0] ridx);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {{IN_PAD_W{1'b0}}, ridx, yw, xw, ts};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (act == ACT_INSERT && !key_is_live(ts) && live_keys.size() < DEPTH)
      live_keys.insert(live_keys.size(), ts);
    else if (act == ACT_CLEAR)
      live_keys.delete();
  endtask

  // Stop offering until every pending result has left the block
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Clear, then fill deep: mostly appends, a few front inserts that shift everything
  task automatic fill_deep();
    logic [TS_W-1:0] k;
    int              i;
    offer(ACT_CLEAR, rand_key(), $urandom(), $urandom(), RIDX_W'($urandom()));
    k = TS_W'($urandom_range(1000, 100000));
    for (i = 0; i < FILL_ENTRIES - 4; i++) begin
      if (i == 100) hold_requests <= hold_requests + 1;
      offer(ACT_INSERT, k, $urandom(), $urandom(), RIDX_W'($urandom()));
      k = k + TS_W'($urandom_range(2, 4096));
    end
    for (i = 3; i >= 0; i--)
      offer(ACT_INSERT, TS_W'(i), $urandom(), $urandom(), RIDX_W'($urandom()));
    // new keys land at the end, a held key is a duplicate
    offer(ACT_INSERT, k, $urandom(), $urandom(), 10'd0);
    offer(ACT_INSERT, {TS_W{1'b1}}, $urandom(), $urandom(), 10'd0);
    offer(ACT_INSERT, TS_W'(2), $urandom(), $urandom(), 10'd0);
    offer(ACT_READ, rand_key(), $urandom(), $urandom(), 10'd0);
    offer(ACT_READ, rand_key(), $urandom(), $urandom(), 10'd1023);
    offer(ACT_READ, rand_key(), $urandom(), $urandom(), RIDX_W'($urandom()));
    offer(ACT_CLEAR, rand_key(), $urandom(), $urandom(), RIDX_W'($urandom()));
  endtask

  initial begin
    int              n;
    int              pick;
    int              clear_odds;
    logic [TS_W-1:0] k;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = ACT_INSERT;
    hold_requests = 0;
    tx_idle_pct   = 16;
    rx_idle_pct   = 79;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty read, key and word extremes, ordering, duplicates, unused action, clear
    offer(ACT_READ,   '0,                 '0,           '0,           10'd0);
    offer(ACT_INSERT, '0,                 32'h80000000, 32'h7FFFFFFF, 10'h3FF);
    offer(ACT_INSERT, {TS_W{1'b1}},       32'h7FFFFFFF, 32'h80000000, 10'd0);
    offer(ACT_INSERT, '0,                 32'h12345678, 32'h9ABCDEF0, 10'd0);
    offer(ACT_INSERT, 48'h8000_0000_0000, 32'hFFFFFFFF, 32'h00000000, 10'd0);
    offer(ACT_INSERT, 48'd1,              32'h00000001, 32'hFFFFFFFE, 10'd0);
    offer(ACT_READ,   {TS_W{1'b1}},       '1,           '1,           10'd0);
    offer(ACT_READ,   '0,                 '0,           '0,           10'd1);
    offer(ACT_READ,   '0,                 '0,           '0,           10'd2);
    offer(ACT_READ,   '0,                 '0,           '0,           10'd3);
    offer(ACT_READ,   '0,                 '0,           '0,           10'd4);
    offer(ACT_READ,   '0,                 '0,           '0,           10'd1023);
    offer(ACT_UNUSED, 48'd7,              '1,           '1,           10'd0);
    offer(ACT_READ,   '0,                 '0,           '0,           10'd3);
    offer(ACT_INSERT, {TS_W{1'b1}},       '0,           '0,           10'd0);
    offer(ACT_CLEAR,  {TS_W{1'b1}},       '1,           '1,           10'h3FF);
    offer(ACT_READ,   '0,                 '0,           '0,           10'd0);
    offer(ACT_INSERT, 48'd42,             32'hCAFE0001, 32'h0000BEEF, 10'd0);
    offer(ACT_READ,   '0,                 '0,           '0,           10'd0);
    wait_drained();

    fill_deep();
    wait_drained();

    // Random: mostly inserts and reads on a small table, with clears and the odd unused action
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        wait_drained();
        tx_idle_pct = 79;
        rx_idle_pct <= 16;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        wait_drained();
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      if (n == RANDOM_ITEMS / 2) hold_requests <= hold_requests + 1;
      pick       = $urandom_range(0, 99);
      clear_odds = (live_keys.size() > 40) ? 20 : 3;
      if (pick < clear_odds) begin
        offer(ACT_CLEAR, rand_key(), $urandom(), $urandom(), RIDX_W'($urandom()));
      end else if (pick < clear_odds + 3) begin
        offer(ACT_UNUSED, rand_key(), $urandom(), $urandom(), RIDX_W'($urandom()));
      end else if (pick < 70) begin
        if (pick >= 60 && live_keys.size() > 0)
          k = live_keys[$urandom_range(0, live_keys.size() - 1)];
        else
          k = rand_key();
        offer(ACT_INSERT, k, $urandom(), $urandom(), RIDX_W'($urandom()));
      end else if ($urandom_range(0, 9) < 7) begin
        offer(ACT_READ, rand_key(), $urandom(), $urandom(),
              RIDX_W'($urandom_range(0, live_keys.size() + 2)));
      end else begin
        offer(ACT_READ, rand_key(), $urandom(), $urandom(), RIDX_W'($urandom()));
      end
    end

    // Let the last results out and watch for strays
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("PASS sorted_timestamp_insert_table_core");
    else
      $display("FAIL sorted_timestamp_insert_table_core");
    $finish;
  end

endmodule
